/* sv/hvcm_pkg.sv */
// hvcm_pkg: shared constants and codes for the heading vote circular mean block.
// Holds the digit-serial datapath geometry and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package hvcm_pkg;

	// item codes
	typedef enum logic {
		OP_VOTE  = 1'b0,
		OP_CLEAR = 1'b1
	} opcode_t;

	// serial datapath: 40-bit words moved 8 bits a cycle
	localparam int DATA_W  = 40;
	localparam int DIGIT_W = 8;
	localparam int DIGITS  = DATA_W / DIGIT_W;
	localparam int DIG_CNT_W = $clog2(DIGITS);
	localparam int TAP_W   = $clog2(DATA_W);

	localparam int VOTE_W    = 8;
	localparam int SECTORS   = 8;
	localparam int SECTOR_W  = 3;
	localparam int ANGLE_W   = 16;
	localparam int CHANGE_W  = 9;

	// sector of a heading: add 7/16 turn, keep top three bits
	localparam logic [ANGLE_W-1:0] SECTOR_OFFSET = 16'd28672;

	// Q24 sector vectors: axis component 1 << 24, diagonal sqrt(2)/2
	localparam int UNIT_SHIFT = 24;
	localparam int DIFF_W     = 9;   // difference of two counters
	localparam int DIAG_SUM_W = 10;  // two counters minus two counters
	localparam int PROD_W     = 35;
	localparam logic [23:0] DIAG_Q24 = 24'd11863283;

	// angle accumulator: 2^31 = pi
	localparam logic [DATA_W-1:0] HALF_TURN = 40'h00_8000_0000;
	localparam logic [31:0] ROUND_HALF = 32'd16384;

	localparam int ATAN_ENTRIES = 24;
	localparam int ITER_W       = 5;

	localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

endpackage

`default_nettype wire

/* sv/heading_vote_circular_mean.sv */
// heading_vote_circular_mean: eight-sector heading vote counters with a
// digit-serial vectoring CORDIC that reports the vote-weighted mean heading.
// Depends on hvcm_pkg.
//
// Usage
// - Input channel (in_valid / in_stall): one transaction per item. opcode
//   OP_VOTE casts a vote from heading and the sign of strength_change,
//   OP_CLEAR zeroes all counters. Counters are updated at the accepting edge.
// - Output channel (out_valid / out_stall): exactly one mean_heading
//   transaction per input item, in order. Binary angle units, pi = 65536 (mod 2^16).
// - Flow: a vote item passes from acceptance through S_PROD, S_SUM, S_FOLD
//   and the CORDIC loop in S_ITER to S_DONE; a clear item goes straight to
//   S_DONE. Each micro-rotation passes x, y and the angle through 40-bit
//   shift registers 8 bits a cycle.
// - Throughput: one item at a time; in_stall is high from acceptance until
//   the result has been moved into the output register.
// - Stall: a finished result waits in the output register while out_stall is
//   high; the next input transaction is still accepted meanwhile, and its
//   result waits in the final state until the register frees.
// - Reset (arst_n low, asynchronous): counters cleared, no result pending.
`default_nettype none

module heading_vote_circular_mean #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 opcode,
	input  wire logic signed [15:0]   heading,
	input  wire logic signed [8:0]    strength_change,
	// output channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [15:0]        mean_heading
);

	localparam int W = hvcm_pkg::DATA_W;
	localparam int D = hvcm_pkg::DIGIT_W;
	localparam int STEPS = (CORDIC_STEPS < hvcm_pkg::ATAN_ENTRIES) ?
		CORDIC_STEPS : hvcm_pkg::ATAN_ENTRIES;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROD,
		S_SUM,
		S_FOLD,
		S_ITER,
		S_DONE
	} state_t;

	state_t state_q;

	logic [hvcm_pkg::SECTORS-1:0][hvcm_pkg::VOTE_W-1:0] votes_q;
	logic                                 zero_q;
	logic                                 out_valid_q;
	logic signed [15:0]                   mean_q;
	logic [hvcm_pkg::ITER_W-1:0]          iter_q;
	logic [hvcm_pkg::DIG_CNT_W-1:0]       dig_q;

	// datapath registers
	logic signed [hvcm_pkg::DIFF_W-1:0]   ax_q, ay_q;
	logic signed [hvcm_pkg::PROD_W-1:0]   px_q, py_q;
	logic [W-1:0]                         x_q, y_q, z_q;
	logic                                 sx_q, sy_q;
	logic                                 cx_q, cy_q, cz_q;

	// ---------------------------------------------------------------
	// Handshakes
	// ---------------------------------------------------------------
	logic in_take, out_take, out_load;

	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign mean_heading = mean_q;
	assign out_take  = out_valid_q & ~out_stall;
	assign out_load  = (state_q == S_DONE) & (~out_valid_q | ~out_stall);

	// ---------------------------------------------------------------
	// Vote update: each counter looks only at its own value
	// ---------------------------------------------------------------
	logic [hvcm_pkg::ANGLE_W-1:0]  sect_sum;
	logic [hvcm_pkg::SECTOR_W-1:0] sector, opp;
	logic                          change_nz, change_pos;
	logic [hvcm_pkg::SECTORS-1:0][hvcm_pkg::VOTE_W-1:0] votes_next;

	always_comb begin
		sect_sum   = heading + hvcm_pkg::SECTOR_OFFSET;
		sector     = sect_sum[hvcm_pkg::ANGLE_W-1 -: hvcm_pkg::SECTOR_W];
		opp        = sector + 3'd4;
		change_nz  = (strength_change != '0);
		change_pos = ~strength_change[hvcm_pkg::CHANGE_W-1];
		for (int k = 0; k < hvcm_pkg::SECTORS; k++) begin
			logic up, down;
			up   = change_nz & (((3'(k) == sector) & change_pos) |
				((3'(k) == opp) & ~change_pos));
			down = change_nz & (((3'(k) == sector) & ~change_pos) |
				((3'(k) == opp) & change_pos));
			votes_next[k] = votes_q[k];
			if (up && votes_q[k] != 8'd255)
				votes_next[k] = votes_q[k] + 8'd1;
			else if (down && votes_q[k] != 8'd0)
				votes_next[k] = votes_q[k] - 8'd1;
		end
	end

	// ---------------------------------------------------------------
	// Vector sum terms from the counters
	// ---------------------------------------------------------------
	logic signed [hvcm_pkg::DIFF_W-1:0]     ax, ay;
	logic signed [hvcm_pkg::DIAG_SUM_W-1:0] bx, by;
	logic signed [hvcm_pkg::PROD_W-1:0]     diag_s, px, py;

	always_comb begin
		ax = $signed({1'b0, votes_q[3]}) - $signed({1'b0, votes_q[7]});
		ay = $signed({1'b0, votes_q[5]}) - $signed({1'b0, votes_q[1]});
		bx = $signed({2'b0, votes_q[2]}) + $signed({2'b0, votes_q[4]})
			- $signed({2'b0, votes_q[0]}) - $signed({2'b0, votes_q[6]});
		by = $signed({2'b0, votes_q[4]}) + $signed({2'b0, votes_q[6]})
			- $signed({2'b0, votes_q[0]}) - $signed({2'b0, votes_q[2]});
		diag_s = $signed(hvcm_pkg::PROD_W'(hvcm_pkg::DIAG_Q24));
		px = hvcm_pkg::PROD_W'(bx) * diag_s;
		py = hvcm_pkg::PROD_W'(by) * diag_s;
	end

	// ---------------------------------------------------------------
	// Digit slice of one micro-rotation
	// ---------------------------------------------------------------
	logic [hvcm_pkg::TAP_W-1:0] base;
	logic [hvcm_pkg::TAP_W-1:0] tap;
	logic [D-1:0]       xs, ys, x_add, y_add, z_add, atan_dig;
	logic               x_cin, y_cin, z_cin, toward;
	logic [W-1:0]       atan_w;
	logic [D:0]         xsum, ysum, zsum;
	logic [W-1:0]       x_sum, y_sum, x_neg, y_neg;
	logic [31:0]        rnd;

	always_comb begin
		base   = 6'(dig_q) * 6'(D);
		atan_w = W'(hvcm_pkg::ATAN_TAB[iter_q]);
		atan_dig = atan_w[base +: D];
		// shifted operand: original bit (base + iter + k), sign beyond the top
		for (int k = 0; k < D; k++) begin
			tap = 6'(iter_q) + 6'(k);
			if ((7'(tap) + 7'(base)) < 7'(W)) begin
				xs[k] = x_q[tap];
				ys[k] = y_q[tap];
			end else begin
				xs[k] = sx_q;
				ys[k] = sy_q;
			end
		end
		toward = ~sy_q;    // y >= 0 rotates clockwise
		x_add  = toward ? ys : ~ys;
		y_add  = toward ? ~xs : xs;
		z_add  = toward ? atan_dig : ~atan_dig;
		x_cin  = (dig_q == '0) ? ~toward : cx_q;
		y_cin  = (dig_q == '0) ? toward : cy_q;
		z_cin  = (dig_q == '0) ? ~toward : cz_q;
		xsum = {1'b0, x_q[D-1:0]} + {1'b0, x_add} + (D+1)'(x_cin);
		ysum = {1'b0, y_q[D-1:0]} + {1'b0, y_add} + (D+1)'(y_cin);
		zsum = {1'b0, z_q[D-1:0]} + {1'b0, z_add} + (D+1)'(z_cin);

		x_sum = (W'(ax_q) << hvcm_pkg::UNIT_SHIFT) + W'(px_q);
		y_sum = (W'(ay_q) << hvcm_pkg::UNIT_SHIFT) + W'(py_q);
		x_neg = -x_q;
		y_neg = -y_q;
		rnd   = z_q[31:0] + hvcm_pkg::ROUND_HALF;
	end

	// ---------------------------------------------------------------
	// Control, counters and output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			votes_q     <= '0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
			mean_q      <= '0;
			iter_q      <= '0;
			dig_q       <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_take)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (opcode == hvcm_pkg::OP_CLEAR) begin
							votes_q <= '0;
							zero_q  <= 1'b1;
							state_q <= S_DONE;
						end else begin
							votes_q <= votes_next;
							state_q <= S_PROD;
						end
					end
				end
				S_PROD: begin
					// the sum is zero only when every term is zero
					zero_q  <= (ax == '0) && (ay == '0) && (bx == '0) && (by == '0);
					state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					iter_q  <= '0;
					dig_q   <= '0;
					state_q <= S_ITER;
				end
				S_ITER: begin
					if (dig_q == hvcm_pkg::DIG_CNT_W'(hvcm_pkg::DIGITS - 1)) begin
						dig_q <= '0;
						if (iter_q == hvcm_pkg::ITER_W'(STEPS - 1))
							state_q <= S_DONE;
						else
							iter_q <= iter_q + 1'b1;
					end else begin
						dig_q <= dig_q + 1'b1;
					end
				end
				S_DONE: begin
					if (out_load) begin
						mean_q  <= zero_q ? '0 : $signed(rnd[30:15]);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Serial datapath
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_PROD: begin
				ax_q <= ax;
				ay_q <= ay;
				px_q <= px;
				py_q <= py;
			end
			S_SUM: begin
				x_q <= x_sum;
				y_q <= y_sum;
			end
			S_FOLD: begin
				// left half-plane: turn by pi first
				if (x_q[W-1]) begin
					x_q  <= x_neg;
					y_q  <= y_neg;
					z_q  <= hvcm_pkg::HALF_TURN;
					sx_q <= x_neg[W-1];
					sy_q <= y_neg[W-1];
				end else begin
					z_q  <= '0;
					sx_q <= x_q[W-1];
					sy_q <= y_q[W-1];
				end
			end
			S_ITER: begin
				x_q  <= {xsum[D-1:0], x_q[W-1:D]};
				y_q  <= {ysum[D-1:0], y_q[W-1:D]};
				z_q  <= {zsum[D-1:0], z_q[W-1:D]};
				cx_q <= xsum[D];
				cy_q <= ysum[D];
				cz_q <= zsum[D];
				// top digit written: signs for the next step
				if (dig_q == hvcm_pkg::DIG_CNT_W'(hvcm_pkg::DIGITS - 1)) begin
					sx_q <= xsum[D-1];
					sy_q <= ysum[D-1];
				end
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> in_stall)
		else $error("input taken while an item is in progress");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && opcode == hvcm_pkg::OP_CLEAR) |=> (votes_q == '0 && zero_q))
		else $error("clear transaction left counters set");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the final state");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER) |-> (iter_q < hvcm_pkg::ITER_W'(STEPS)))
		else $error("CORDIC step count overrun");

endmodule

`default_nettype wire

/* bench/tb.sv */
// tb: self-checking bench for heading_vote_circular_mean.
// Predicts every mean_heading from its own vote tally and CORDIC, then checks the DUT output.
// Depends on hvcm_pkg and heading_vote_circular_mean.
`timescale 1ns / 100ps

module tb;

	localparam int CORDIC_STEPS = 16;
	localparam int DRAIN_CYCLES = 120;   // stray watch, longer than one vote item takes
	localparam int WALK_ITEMS   = 1400;

	// sector boundaries: add 7/16 turn, top three bits give the sector
	localparam logic [15:0] SECTOR_SHIFT = 16'd28672;
	localparam int          SECTOR_SPAN  = 8192;
	localparam int          EDGE_BASE    = 36864;   // lower edge of sector 0, mod 2^16

	// Q24 unit vector components and a 2^31 = pi angle accumulator
	localparam longint AXIS_COMPONENT = 64'sd16777216;
	localparam longint DIAG_COMPONENT = 64'sd11863283;
	localparam longint PI_ANGLE       = 64'sd2147483648;
	localparam longint ARCTAN_STEP [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
		64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
		64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	hvcm_pkg::opcode_t  opcode = hvcm_pkg::OP_VOTE;
	logic signed [15:0] heading = '0;
	logic signed [8:0]  strength_change = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] mean_heading;

	// bench copy of the sector counters and the means still owed by the DUT
	logic [7:0]         sector_tally [8];
	logic signed [15:0] expected_means [$];
	int                 mean_errors = 0;

	// sender burst bookkeeping
	int burst_left = 0;

	// receiver stall pattern
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;

	heading_vote_circular_mean #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.heading(heading),
		.strength_change(strength_change),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mean_heading(mean_heading)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------------

	function automatic void raise_sector(input logic [2:0] s);
		if (sector_tally[s] != 8'hFF)
			sector_tally[s] = sector_tally[s] + 8'd1;
	endfunction

	function automatic void lower_sector(input logic [2:0] s);
		if (sector_tally[s] != 8'h00)
			sector_tally[s] = sector_tally[s] - 8'd1;
	endfunction

	// Vote-weighted mean of the sector centres, vectoring CORDIC with floor shifts.
	function automatic logic signed [15:0] circular_mean();
		longint w [8];
		longint x, y, z, nx, ny, rounded;
		int i;
		for (i = 0; i < 8; i++)
			w[i] = longint'(sector_tally[i]);
		x = (w[3] - w[7]) * AXIS_COMPONENT + (w[2] + w[4] - w[0] - w[6]) * DIAG_COMPONENT;
		y = (w[5] - w[1]) * AXIS_COMPONENT + (w[4] + w[6] - w[0] - w[2]) * DIAG_COMPONENT;
		if (x == 0 && y == 0)
			return 16'sd0;
		z = 0;
		// left half-plane: reflect through the origin and start from pi
		if (x < 0) begin
			x = -x;
			y = -y;
			z = PI_ANGLE;
		end
		for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + ARCTAN_STEP[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - ARCTAN_STEP[i];
			end
			x = nx;
			y = ny;
		end
		// round half up to binary angle units; pi wraps to 0
		rounded = (z + 64'sd16384) >>> 15;
		return rounded[15:0];
	endfunction

	// Update the bench tally for one accepted transaction and queue its mean.
	function automatic void tally_item(input hvcm_pkg::opcode_t op, input logic [15:0] hdg,
			input logic [8:0] chg);
		logic [15:0] shifted;
		logic [2:0]  sec, opp;
		int i;
		if (op == hvcm_pkg::OP_CLEAR) begin
			for (i = 0; i < 8; i++)
				sector_tally[i] = 8'h00;
		end else begin
			shifted = hdg + SECTOR_SHIFT;
			sec = shifted[15:13];
			opp = sec + 3'd4;
			if (chg != 9'h000) begin
				if (!chg[8]) begin
					raise_sector(sec);
					lower_sector(opp);
				end else begin
					lower_sector(sec);
					raise_sector(opp);
				end
			end
		end
		expected_means.push_back(circular_mean());
	endfunction

	initial begin
		for (int i = 0; i < 8; i++)
			sector_tally[i] = 8'h00;
	end

	// ---------------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------------

	function automatic logic [15:0] heading_in_sector(input int k);
		return 16'(k * SECTOR_SPAN + EDGE_BASE + int'($urandom_range(0, SECTOR_SPAN - 1)));
	endfunction

	function automatic logic [8:0] random_strength(input bit up);
		int m;
		m = int'($urandom_range(1, 255));
		return up ? 9'(m) : 9'(-m);
	endfunction

	// Present one transaction; the sender idles between bursts of random length.
	// valid stays high from one accepted transaction to the next within a burst.
	task automatic send_item(input hvcm_pkg::opcode_t op, input logic [15:0] hdg,
			input logic [8:0] chg);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(1, 120);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		opcode          <= op;
		heading         <= hdg;
		strength_change <= chg;
		// in_stall is sampled before the edge's updates land
		do @(posedge clk); while (in_stall);
		burst_left--;
		tally_item(op, hdg, chg);
	endtask

	// ---------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------

	// No votes at all: zero strength change must leave the mean at 0, including
	// headings at both ends of the range.
	task automatic test_empty_tally();
		send_item(hvcm_pkg::OP_VOTE, 16'h0000, 9'h000);
		send_item(hvcm_pkg::OP_VOTE, 16'h8000, 9'h000);
		send_item(hvcm_pkg::OP_VOTE, 16'h7FFF, 9'h000);
	endtask

	// A lone vote in the wrap-around sector gives a half turn, which wraps to near 0.
	// Clears ignore their heading and strength fields.
	task automatic test_half_turn_and_clear();
		send_item(hvcm_pkg::OP_VOTE, 16'h7FFF, 9'h0FF);
		send_item(hvcm_pkg::OP_CLEAR, 16'h7FFF, 9'h101);
		send_item(hvcm_pkg::OP_CLEAR, 16'h8000, 9'h0FF);
	endtask

	// Lower edge of every sector (inside) and one unit below it (previous sector),
	// with both extreme strengths of each sign.
	task automatic test_sector_edges();
		logic [15:0] edge_hdg;
		for (int k = 0; k < 8; k++) begin
			edge_hdg = 16'(k * SECTOR_SPAN + EDGE_BASE);
			send_item(hvcm_pkg::OP_VOTE, edge_hdg, (k % 2 == 0) ? 9'h0FF : 9'h001);
			send_item(hvcm_pkg::OP_VOTE, edge_hdg - 16'd1,
				(k % 2 == 0) ? 9'h101 : 9'h1FF);
		end
		// zero change with a populated tally still reports the mean
		send_item(hvcm_pkg::OP_VOTE, 16'($urandom_range(0, 65535)), 9'h000);
		send_item(hvcm_pkg::OP_CLEAR, 16'($urandom_range(0, 65535)),
			9'($urandom_range(0, 511)));
	endtask

	// Push one sector's counter to saturation at 255, then pull it back with reverse votes.
	task automatic test_saturation();
		int k;
		k = $urandom_range(0, 7);
		send_item(hvcm_pkg::OP_CLEAR, 16'h0000, 9'h000);
		repeat (280) send_item(hvcm_pkg::OP_VOTE, heading_in_sector(k),
			random_strength(1'b1));
		repeat (20) send_item(hvcm_pkg::OP_VOTE, heading_in_sector(k),
			random_strength(1'b0));
	endtask

	// Segments that favour one sector and one sign, with stray headings, zero
	// changes and the odd clear mixed in; counters climb, saturate and drain.
	task automatic test_random_walk(input int n_items);
		int sent, seg_len, focus, up_pct, r, k;
		sent = 0;
		while (sent < n_items) begin
			seg_len = $urandom_range(10, 80);
			focus   = $urandom_range(0, 7);
			up_pct  = $urandom_range(0, 100);
			for (int j = 0; j < seg_len && sent < n_items; j++) begin
				r = $urandom_range(0, 99);
				if (r < 2) begin
					send_item(hvcm_pkg::OP_CLEAR, 16'($urandom_range(0, 65535)),
						9'($urandom_range(0, 511)));
				end else if (r < 10) begin
					send_item(hvcm_pkg::OP_VOTE, 16'($urandom_range(0, 65535)),
						9'(int'($urandom_range(0, 510)) - 255));
				end else if (r < 14) begin
					send_item(hvcm_pkg::OP_VOTE, heading_in_sector(focus), 9'h000);
				end else begin
					k = ($urandom_range(0, 99) < 70) ? focus : int'($urandom_range(0, 7));
					send_item(hvcm_pkg::OP_VOTE, heading_in_sector(k),
						random_strength($urandom_range(0, 99) < up_pct));
				end
				sent++;
			end
		end
	endtask

	// ---------------------------------------------------------------------------
	// Receiver: stall pattern changes to a random mode after a random hold:
	//   0 never stalls, 1 light random, 2 heavy random, 3 long holds
	// ---------------------------------------------------------------------------
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_left  <= $urandom_range(50, 600);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= ($urandom_range(0, 99) < 30);
			end
			2: begin
				out_stall <= ($urandom_range(0, 99) < 85);
			end
			default: begin
				if (hold_left == 0) begin
					out_stall <= ~out_stall;
					hold_left <= out_stall ? $urandom_range(0, 40) : $urandom_range(1, 150);
				end else begin
					hold_left <= hold_left - 1;
				end
			end
		endcase
	end

	// ---------------------------------------------------------------------------
	// Checker: every output transaction against the oldest outstanding mean
	// ---------------------------------------------------------------------------
	always @(posedge clk) begin
		logic signed [15:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_means.size() == 0) begin
				mean_errors++;
				if (mean_errors <= 10)
					$display("unexpected mean_heading transaction: %0d", mean_heading);
			end else begin
				want = expected_means.pop_front();
				if (mean_heading !== want) begin
					mean_errors++;
					if (mean_errors <= 10)
						$display("mean_heading mismatch: expected %0d, got %0d",
							want, mean_heading);
				end
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------------
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_tally();
		test_half_turn_and_clear();
		test_sector_edges();
		test_saturation();
		test_random_walk(WALK_ITEMS);
		in_valid <= 1'b0;

		// let every owed mean arrive, then watch a while for strays
		while (expected_means.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mean_errors == 0 && expected_means.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// run limit, several times the slowest legal run
	initial begin
		#20_000_000;
		$display("tb failed");
		$finish;
	end

endmodule
